// File: rtl/y2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared constants, coefficient table and pipeline types for the YUV 4:2:0
// quad to RGB565 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  // Fixed-point constants of the conversion
  localparam int unsigned CHROMA_DIV  = 76309;
  localparam int unsigned CHROMA_HALF = CHROMA_DIV / 2;
  localparam int unsigned LUMA_GAIN   = 76309;
  localparam int unsigned LUMA_ROUND  = 32768;

  // Reciprocal of the chroma divisor, scaled by 2^RECIP_SHIFT (floor)
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [23:0] RECIP = 24'((64'd1 << RECIP_SHIFT) / CHROMA_DIV);

  localparam logic [2:0] MATRIX_RESET = 3'd6;

  // Coefficient columns
  typedef enum logic [1:0] {
    COL_RV = 2'd0,
    COL_BU = 2'd1,
    COL_GU = 2'd2,
    COL_GV = 2'd3
  } coef_col_t;

  // Colour matrix rows: red from V, blue from U, green from U, green from V
  localparam logic [17:0] COEF_TAB [8][4] = '{
    '{18'd117504, 18'd138453, 18'd13954, 18'd34903},
    '{18'd117504, 18'd138453, 18'd13954, 18'd34903},
    '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
    '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
    '{18'd104448, 18'd132798, 18'd24759, 18'd53109},
    '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
    '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
    '{18'd117579, 18'd136230, 18'd16907, 18'd35559}
  };

  function automatic logic [17:0] coef_of(input logic [2:0] sel, input coef_col_t col);
    return COEF_TAB[sel][col];
  endfunction

  // Signed chroma offset, magnitude at most 232
  typedef logic signed [8:0] chroma_off_t;

  // Stage load enables
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } chroma_en_t;

  typedef struct packed {
    logic d;
    logic e;
  } luma_en_t;

endpackage

// File: rtl/y2r_chroma_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_chroma_lane
// One chroma offset: +/-coef*(c-128)/76309, rounded half away from zero.
// Three stages: product, reciprocal multiply, remainder correction and sign.
// ----------------------------------------------------------------------------
module y2r_chroma_lane (
  input  logic                 clk,
  input  y2r_pkg::chroma_en_t  en,
  input  logic [7:0]           sample,
  input  logic [17:0]          coef,
  input  logic                 negate,
  output y2r_pkg::chroma_off_t offset
);
  import y2r_pkg::*;

  logic [7:0]  mag;
  logic        neg_nxt;
  logic [25:0] num_nxt;
  logic [25:0] num_a_r;
  logic        neg_a_r;

  logic [25:0] n_nxt;
  logic [49:0] prod_nxt;
  logic [25:0] n_b_r;
  logic [49:0] prod_b_r;
  logic        neg_b_r;

  logic [7:0]  q_est;
  logic [25:0] q_back;
  logic [25:0] rem;
  logic [8:0]  q;
  chroma_off_t off_nxt;
  chroma_off_t off_c_r;

  // Stage A: magnitude of the centred sample times the coefficient
  always_comb begin
    if (sample[7]) begin
      mag = sample - 8'd128;
    end else begin
      mag = 8'd128 - sample;
    end
    neg_nxt = (~sample[7]) ^ negate;
    num_nxt = {8'd0, coef} * {18'd0, mag};
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      num_a_r <= num_nxt;
      neg_a_r <= neg_nxt;
    end
  end

  // Stage B: add half divisor, multiply by the scaled reciprocal
  assign n_nxt    = num_a_r + 26'(CHROMA_HALF);
  assign prod_nxt = {24'd0, n_nxt} * {26'd0, RECIP};

  always_ff @(posedge clk) begin
    if (en.b) begin
      n_b_r    <= n_nxt;
      prod_b_r <= prod_nxt;
      neg_b_r  <= neg_a_r;
    end
  end

  // Stage C: estimate is exact or one short; fix with the remainder
  always_comb begin
    q_est   = prod_b_r[RECIP_SHIFT +: 8];
    q_back  = {18'd0, q_est} * 26'(CHROMA_DIV);
    rem     = n_b_r - q_back;
    q       = {1'b0, q_est} + {8'd0, (rem >= 26'(CHROMA_DIV))};
    off_nxt = neg_b_r ? -$signed(q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      off_c_r <= off_nxt;
    end
  end

  assign offset = off_c_r;

endmodule

// File: rtl/y2r_luma_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_luma_lane
// One pixel of the quad: adds chroma offsets to luma, scales to 8-bit levels
// with clamping and packs the RGB565 word.
// ----------------------------------------------------------------------------
module y2r_luma_lane (
  input  logic                 clk,
  input  y2r_pkg::luma_en_t    en,
  input  logic [7:0]           y,
  input  y2r_pkg::chroma_off_t r_off,
  input  y2r_pkg::chroma_off_t gu_off,
  input  y2r_pkg::chroma_off_t gv_off,
  input  y2r_pkg::chroma_off_t b_off,
  output logic [15:0]          pixel
);
  import y2r_pkg::*;

  // 76309*(t-16)+32768 as a signed value
  function automatic logic signed [28:0] scaled(input logic signed [10:0] t);
    logic signed [10:0] w;
    logic signed [28:0] g29;
    logic signed [28:0] w29;
    w   = t - 11'sd16;
    g29 = 29'(LUMA_GAIN);
    w29 = 29'(w);
    return g29 * w29 + 29'(LUMA_ROUND);
  endfunction

  // Arithmetic shift by 16, clamped to 0..255
  function automatic logic [7:0] level(input logic signed [28:0] p);
    logic [7:0] lv;
    if (p[28]) begin
      lv = 8'd0;
    end else if (p[27:24] != 4'd0) begin
      lv = 8'd255;
    end else begin
      lv = p[23:16];
    end
    return lv;
  endfunction

  logic signed [10:0] y_s;
  logic signed [10:0] t_r;
  logic signed [10:0] t_g;
  logic signed [10:0] t_b;
  logic signed [28:0] p_r_r, p_g_r, p_b_r;
  logic [7:0]         lv_r, lv_g, lv_b;
  logic [15:0]        pixel_nxt;
  logic [15:0]        pixel_r;

  // Stage D: channel indices and scaling products
  always_comb begin
    y_s = $signed({3'b000, y});
    t_r = y_s + $signed({{2{r_off[8]}}, r_off});
    t_g = y_s + $signed({{2{gu_off[8]}}, gu_off}) + $signed({{2{gv_off[8]}}, gv_off});
    t_b = y_s + $signed({{2{b_off[8]}}, b_off});
  end

  always_ff @(posedge clk) begin
    if (en.d) begin
      p_r_r <= scaled(t_r);
      p_g_r <= scaled(t_g);
      p_b_r <= scaled(t_b);
    end
  end

  // Stage E: clamp and pack 5:6:5
  always_comb begin
    lv_r      = level(p_r_r);
    lv_g      = level(p_g_r);
    lv_b      = level(p_b_r);
    pixel_nxt = {lv_r[7:3], lv_g[7:2], lv_b[7:3]};
  end

  always_ff @(posedge clk) begin
    if (en.e) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign pixel = pixel_r;

endmodule

// File: rtl/yuv420_to_rgb565_quad_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_rgb565_quad_top
// Converts a 2x2 luma quad with its shared U/V pair into four RGB565 pixels.
// ----------------------------------------------------------------------------
// One quad is accepted per clock while the output is not stalled; its four
// pixels appear in a single output beat. Four chroma lanes (three stages each:
// product, reciprocal multiply, rounding correction) feed four pixel lanes
// (two stages: scaling multiply, clamp and pack), whose registered words form
// the output beat. Each stage has its own valid bit, so a stalled output
// only holds back as many stages as are full. matrix_select (reset 6) picks the
// coefficient row and should be written only while the pipeline is empty.
module yuv420_to_rgb565_quad_top (
  input  logic        clk,
  input  logic        rst_n,
  // cfg: matrix_select [2:0]
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // y_top_left, y_top_right, y_bottom_left, y_bottom_right, u_sample, v_sample
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
  output logic [63:0] out_tdata
);
  import y2r_pkg::*;

  logic [2:0]  matrix_r;
  logic [5:1]  valid_r;
  logic [5:1]  rdy;
  logic [5:1]  en;
  logic [7:0]  y_s1_r [4];
  logic [7:0]  y_s2_r [4];
  logic [7:0]  y_s3_r [4];
  logic [7:0]  u_in, v_in;
  chroma_en_t  cen;
  luma_en_t    len;
  chroma_off_t rv_off, bu_off, gu_off, gv_off;
  logic [15:0] pix [4];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= MATRIX_RESET;
    end else if (cfg_wr_en) begin
      matrix_r <= cfg_wr_data;
    end
  end

  // Per-stage flow control: a stage loads when empty or when it drains
  always_comb begin
    rdy[5] = !valid_r[5] || out_tready;
    for (int k = 4; k >= 1; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    en = rdy;
  end

  assign in_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[1]) valid_r[1] <= in_tvalid;
      for (int k = 2; k <= 5; k++) begin
        if (en[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // Luma travels alongside the chroma stages
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (en[1]) y_s1_r[i] <= in_tdata[8*i +: 8];
      if (en[2]) y_s2_r[i] <= y_s1_r[i];
      if (en[3]) y_s3_r[i] <= y_s2_r[i];
    end
  end

  assign u_in = in_tdata[39:32];
  assign v_in = in_tdata[47:40];
  assign cen  = '{a: en[1], b: en[2], c: en[3]};
  assign len  = '{d: en[4], e: en[5]};

  // Chroma lanes
  y2r_chroma_lane u_rv (
    .clk(clk), .en(cen), .sample(v_in), .coef(coef_of(matrix_r, COL_RV)),
    .negate(1'b0), .offset(rv_off)
  );
  y2r_chroma_lane u_bu (
    .clk(clk), .en(cen), .sample(u_in), .coef(coef_of(matrix_r, COL_BU)),
    .negate(1'b0), .offset(bu_off)
  );
  y2r_chroma_lane u_gu (
    .clk(clk), .en(cen), .sample(u_in), .coef(coef_of(matrix_r, COL_GU)),
    .negate(1'b1), .offset(gu_off)
  );
  y2r_chroma_lane u_gv (
    .clk(clk), .en(cen), .sample(v_in), .coef(coef_of(matrix_r, COL_GV)),
    .negate(1'b1), .offset(gv_off)
  );

  // Pixel lanes
  for (genvar i = 0; i < 4; i++) begin : g_pix
    y2r_luma_lane u_luma (
      .clk(clk), .en(len), .y(y_s3_r[i]),
      .r_off(rv_off), .gu_off(gu_off), .gv_off(gv_off), .b_off(bu_off),
      .pixel(pix[i])
    );
  end

  // Merge the four pixels into the output beat
  assign out_tvalid = valid_r[5];
  assign out_tdata  = {pix[3], pix[2], pix[1], pix[0]};

endmodule

// File: test/yuv_quad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_quad_checker
// Watches the quad input, the pixel output and the matrix register writes of
// the YUV 4:2:0 quad converter. Each input beat is converted to four RGB565
// pixels by a local predictor. Each output beat is compared, pixel by pixel,
// with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module yuv_quad_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // y_top_left, y_top_right, y_bottom_left, y_bottom_right, u_sample, v_sample
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
  input  logic [63:0] out_tdata,
  output int          fail_count,
  output int          quads_pending
);

  import y2r_pkg::*;

  localparam longint CHROMA_SCALE = 76309;
  localparam longint CHROMA_BIAS  = 38154;
  localparam longint LUMA_SCALE   = 76309;
  localparam longint LUMA_BIAS    = 32768;

  logic [2:0]  matrix_sel;
  logic [63:0] expected_pixels [$];
  logic [63:0] want;
  int          beats_seen;

  // Coefficient of one column of the colour matrix
  function automatic int matrix_coef(input logic [2:0] sel, input coef_col_t col);
    int row [4];
    case (sel)
      3'd0, 3'd1: row = '{117504, 138453, 13954, 34903};
      3'd4:       row = '{104448, 132798, 24759, 53109};
      3'd7:       row = '{117579, 136230, 16907, 35559};
      default:    row = '{104597, 132201, 25675, 53279};
    endcase
    return row[int'(col)];
  endfunction

  // coef*(c-128)/76309, rounded half away from zero
  function automatic longint chroma_term(input longint num);
    if (num > 0) begin
      return (num + CHROMA_BIAS) / CHROMA_SCALE;
    end
    return -((-num + CHROMA_BIAS) / CHROMA_SCALE);
  endfunction

  // Luma index to 8-bit level, clamped to black and white
  function automatic logic [7:0] luma_level(input longint idx);
    longint lin;
    lin = LUMA_SCALE * (idx - 16) + LUMA_BIAS;
    if (lin < 0) begin
      return 8'h00;
    end
    lin = lin / 65536;
    if (lin > 255) begin
      return 8'hFF;
    end
    return lin[7:0];
  endfunction

  // Four RGB565 pixels of one quad under the given matrix row
  function automatic logic [63:0] quad_to_rgb565(input logic [47:0] quad,
                                                 input logic [2:0]  sel);
    longint     u_off, v_off, red_off, green_off, blue_off, luma;
    logic [7:0] lr, lg, lb;
    logic [63:0] pixels;
    u_off     = longint'(quad[39:32]) - 128;
    v_off     = longint'(quad[47:40]) - 128;
    red_off   = chroma_term(longint'(matrix_coef(sel, COL_RV)) * v_off);
    blue_off  = chroma_term(longint'(matrix_coef(sel, COL_BU)) * u_off);
    green_off = chroma_term(-longint'(matrix_coef(sel, COL_GU)) * u_off)
              + chroma_term(-longint'(matrix_coef(sel, COL_GV)) * v_off);
    for (int k = 0; k < 4; k++) begin
      luma = longint'(quad[8*k +: 8]);
      lr = luma_level(luma + red_off);
      lg = luma_level(luma + green_off);
      lb = luma_level(luma + blue_off);
      pixels[16*k +: 16] = {lr[7:3], lg[7:2], lb[7:3]};
    end
    return pixels;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH result %0d: %s", beats_seen, what);
    fail_count++;
  endtask

  task automatic check_pixel(input string name, input logic [15:0] exp_px,
                             input logic [15:0] got_px);
    if (got_px !== exp_px) begin
      report_mismatch($sformatf("%s expected %h got %h", name, exp_px, got_px));
    end
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    if (!rst_n) begin
      matrix_sel = MATRIX_RESET;
      expected_pixels.delete();
      beats_seen = 0;
      quads_pending <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(quad_to_rgb565(in_tdata, matrix_sel));
      end
      if (cfg_wr_en) begin
        matrix_sel = cfg_wr_data;
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("beat %h with no quad outstanding", out_tdata));
        end else begin
          want = expected_pixels.pop_front();
          check_pixel("pixel_top_left",     want[15:0],  out_tdata[15:0]);
          check_pixel("pixel_top_right",    want[31:16], out_tdata[31:16]);
          check_pixel("pixel_bottom_left",  want[47:32], out_tdata[47:32]);
          check_pixel("pixel_bottom_right", want[63:48], out_tdata[63:48]);
        end
        beats_seen++;
      end
      quads_pending <= expected_pixels.size();
    end
  end

endmodule

// File: test/yuv420_to_rgb565_quad_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_rgb565_quad_top_tb
// Stimulus and verdict for the YUV 4:2:0 quad to RGB565 converter. A directed
// set under the reset matrix row is followed by random quads under every row,
// with bursty input, a wandering output stall and one long output hold-off.
// Prediction and comparison live in yuv_quad_checker.
// ----------------------------------------------------------------------------
module yuv420_to_rgb565_quad_top_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_QUADS  = 150;
  localparam int SETTLE       = 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  int          fail_count;
  int          quads_pending;
  int          cycle_count;
  int          burst_left;
  int          gap_max;
  logic        stall_req;

  yuv420_to_rgb565_quad_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  yuv_quad_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .quads_pending (quads_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit; the counter starts from zero
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output stall: random modes over random stretches, long hold on request
  initial begin : sink
    int  mode;
    int  span;
    bit  stall_seen;
    out_tready = 1'b0;
    stall_seen = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(posedge clk);
        if (stall_req && !stall_seen) begin
          stall_seen = 1'b1;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          if (!stall_req) begin
            stall_seen = 1'b0;
          end
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  function automatic logic [47:0] pack_quad(input logic [7:0] ytl, input logic [7:0] ytr,
                                            input logic [7:0] ybl, input logic [7:0] ybr,
                                            input logic [7:0] u, input logic [7:0] v);
    return {v, u, ybr, ybl, ytr, ytl};
  endfunction

  // Random quad, biased towards neutral chroma, the black and white knees,
  // saturated chroma and equal luma across the quad
  function automatic logic [47:0] random_quad();
    logic [7:0] y [4];
    logic [7:0] u, v;
    int         kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      y[k] = 8'($urandom);
    end
    u = 8'($urandom);
    v = 8'($urandom);
    case (kind)
      6: begin
        u = 8'($urandom_range(125, 131));
        v = 8'($urandom_range(125, 131));
      end
      7: begin
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 3))
            0:       y[k] = 8'($urandom_range(0, 3));
            1:       y[k] = 8'($urandom_range(13, 19));
            2:       y[k] = 8'($urandom_range(232, 238));
            default: y[k] = 8'($urandom_range(252, 255));
          endcase
        end
      end
      8: begin
        u = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      9: begin
        for (int k = 1; k < 4; k++) begin
          y[k] = y[0];
        end
      end
      default: ;
    endcase
    return pack_quad(y[0], y[1], y[2], y[3], u, v);
  endfunction

  // Offer one quad, in bursts separated by random gaps
  task automatic push_quad(input logic [47:0] quad);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= quad;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // Stop offering and wait for every outstanding quad to come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (quads_pending != 0);
  endtask

  task automatic set_matrix(input logic [2:0] sel);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sel;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [2:0] sel;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 3'd0;
    in_tvalid   = 1'b0;
    in_tdata    = 48'd0;
    stall_req   = 1'b0;
    burst_left  = 0;
    gap_max     = 3;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed quads under the reset row
    push_quad(pack_quad(8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128));
    push_quad(pack_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128));
    push_quad(pack_quad(8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd128));
    push_quad(pack_quad(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128));
    push_quad(pack_quad(8'd17,  8'd18,  8'd19,  8'd20,  8'd128, 8'd128));
    push_quad(pack_quad(8'd234, 8'd236, 8'd254, 8'd253, 8'd128, 8'd128));
    // below black through chroma
    push_quad(pack_quad(8'd0,   8'd255, 8'd16,  8'd235, 8'd0,   8'd0));
    // above white through chroma
    push_quad(pack_quad(8'd255, 8'd0,   8'd235, 8'd16,  8'd255, 8'd255));
    push_quad(pack_quad(8'd128, 8'd127, 8'd129, 8'd100, 8'd0,   8'd255));
    push_quad(pack_quad(8'd128, 8'd127, 8'd129, 8'd100, 8'd255, 8'd0));
    push_quad(pack_quad(8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA));
    push_quad(pack_quad(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55));
    push_quad(pack_quad(8'd100, 8'd101, 8'd102, 8'd103, 8'd127, 8'd129));
    push_quad(pack_quad(8'd60,  8'd61,  8'd62,  8'd63,  8'd129, 8'd127));
    push_quad(pack_quad(8'd0,   8'd0,   8'd255, 8'd255, 8'd1,   8'd254));
    push_quad(pack_quad(8'd255, 8'd255, 8'd0,   8'd0,   8'd254, 8'd1));

    // Random quads under every matrix row, extremes first
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0:       sel = 3'd0;
        1:       sel = 3'd7;
        2:       sel = 3'd4;
        3:       sel = 3'd1;
        4:       sel = 3'd3;
        5:       sel = 3'd5;
        6:       sel = 3'd2;
        7:       sel = 3'd6;
        default: sel = 3'($urandom_range(0, 7));
      endcase
      set_matrix(sel);
      gap_max = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 10);
      for (int i = 0; i < PHASE_QUADS; i++) begin
        // long output hold-off while quads keep coming, so the pipe fills
        if (phase == 0 && i == 30) begin
          stall_req <= 1'b1;
        end
        if (phase == 0 && i == 90) begin
          stall_req <= 1'b0;
        end
        push_quad(random_quad());
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
